// ===== rtl/mkde_pkg.sv =====
package mkde_pkg;

  // Item modes carried in the input tuser field.
  localparam logic [2:0] MODE_SETUP  = 3'd0;
  localparam logic [2:0] MODE_EVAL   = 3'd1;
  localparam logic [2:0] MODE_LUT    = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_STAGE  = 3'd4;
  localparam logic [2:0] MODE_COMMIT = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;

  // Kernel kinds per dimension.
  localparam logic [2:0] KIND_GAUSS = 3'd0;
  localparam logic [2:0] KIND_EPA   = 3'd1;
  localparam logic [2:0] KIND_VM    = 3'd2;
  localparam logic [2:0] KIND_BOX   = 3'd3;
  localparam logic [2:0] KIND_DELTA = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DIMS   = 2'd0;
  localparam logic [1:0] CFG_POINTS = 2'd1;
  localparam logic [1:0] CFG_CUTOFF = 2'd2;

  localparam logic [47:0] ACC_SAT = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] SQ_SAT  = 32'hFFFF_FFFF;
  localparam logic [31:0] ONE_Q16 = 32'd65536;
  localparam logic [17:0] PHASE_SCALE = 18'd10430;
  localparam logic [17:0] LOG2E_Q8    = 18'd369;

  // Quarter wave of cosine in Q1.14, 16 steps per quarter turn.
  function automatic logic [14:0] cos_quarter(input logic [4:0] r);
    logic [14:0] v;
    case (r)
      5'd0:  v = 15'd16384;
      5'd1:  v = 15'd16305;
      5'd2:  v = 15'd16069;
      5'd3:  v = 15'd15679;
      5'd4:  v = 15'd15137;
      5'd5:  v = 15'd14449;
      5'd6:  v = 15'd13623;
      5'd7:  v = 15'd12665;
      5'd8:  v = 15'd11585;
      5'd9:  v = 15'd10394;
      5'd10: v = 15'd9102;
      5'd11: v = 15'd7723;
      5'd12: v = 15'd6270;
      5'd13: v = 15'd4756;
      5'd14: v = 15'd3196;
      5'd15: v = 15'd1606;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Full-turn cosine from a 6-bit phase.
  function automatic logic signed [15:0] cos_q14(input logic [5:0] idx);
    logic [4:0] r;
    logic signed [15:0] v;
    r = {1'b0, idx[3:0]};
    case (idx[5:4])
      2'd0: v = $signed({1'b0, cos_quarter(r)});
      2'd1: v = -$signed({1'b0, cos_quarter(5'd16 - r)});
      2'd2: v = -$signed({1'b0, cos_quarter(r)});
      default: v = $signed({1'b0, cos_quarter(5'd16 - r)});
    endcase
    return v;
  endfunction

  // 2^(k/16) in Q1.15.
  function automatic logic [15:0] exp2_frac(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:  v = 16'd32768;
      4'd1:  v = 16'd34219;
      4'd2:  v = 16'd35734;
      4'd3:  v = 16'd37316;
      4'd4:  v = 16'd38968;
      4'd5:  v = 16'd40693;
      4'd6:  v = 16'd42495;
      4'd7:  v = 16'd44376;
      4'd8:  v = 16'd46341;
      4'd9:  v = 16'd48393;
      4'd10: v = 16'd50535;
      4'd11: v = 16'd52773;
      4'd12: v = 16'd55109;
      4'd13: v = 16'd57549;
      4'd14: v = 16'd60097;
      default: v = 16'd62757;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mkde_ram.sv =====
module mkde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mixed_kernel_density_eval_unit.sv =====
// Weighted mixed-kernel density evaluator.
// Input requests arrive on s_tvalid/s_tready with the mode in s_tuser and the
// other fields in s_tdata. Every request gives exactly one result on
// m_tvalid/m_tready: the density on a read, otherwise zero, plus a status bit.
// Configuration writes use cfg_valid/cfg_ready, which is always ready; write
// them only while the block is idle.
// Setup, coordinate, table, stage and clear requests pass through the execute
// and output states; a read also passes a read state, as it goes through the
// accumulator memory's registered read port.
// A commit walks every active evaluation point and, within it, the active
// dimensions in turn through one shared multiplier; a kernel that rejects the
// point ends it early, with no write to its accumulator.
// One request is in flight at a time; s_tready drops for its whole duration.
// A finished result sits in the output register while the next request is
// taken; if the receiver stalls, the block holds the next result until the
// output register frees up.
// Reset loads one dimension, one point and a cutoff of 768, and clears dimension
// setup, staged coordinates and all accumulators at once; there is no clearing pass.
module mixed_kernel_density_eval_unit #(
  parameter int MAX_DIMS   = 8,
  parameter int MAX_EVAL   = 256,
  parameter int TABLE_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // dim_index[2:0], point_index[10:3], lut_address[22:11], value[38:23],
  // kernel_kind[41:39], lut_side[48:42], weight[64:49], zero fill above
  input  logic [71:0] s_tdata,
  // mode[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // density[47:0], status[48], zero fill above
  output logic [55:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mkde_pkg::*;

  localparam int TBL_WORDS = TABLE_SIDE * TABLE_SIDE;
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int GIW = (MAX_EVAL > 1) ? $clog2(MAX_EVAL) : 1;
  localparam int EV_DEPTH = MAX_DIMS * MAX_EVAL;
  localparam int TB_DEPTH = MAX_DIMS * TBL_WORDS;
  localparam int EAW = (EV_DEPTH > 1) ? $clog2(EV_DEPTH) : 1;
  localparam int TAW = (TB_DEPTH > 1) ? $clog2(TB_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_RDACC, S_CUT, S_PT, S_FETCH, S_COORD, S_TBL, S_KERN,
    S_VM1, S_VM2, S_SQ, S_ACC, S_EXP1, S_EXP2, S_EXP3, S_EXP4, S_WR, S_OUT
  } state_t;

  state_t state;

  // Configuration and per-dimension setup.
  logic [3:0]  act_dims;
  logic [8:0]  act_pts;
  logic [15:0] cutoff;
  logic [2:0]  dim_kernel [MAX_DIMS];
  logic signed [15:0] dim_scale [MAX_DIMS];
  logic [6:0]  dim_table_side [MAX_DIMS];
  logic signed [15:0] staged [MAX_DIMS];
  logic [MAX_EVAL-1:0] acc_valid;

  // Latched request.
  logic [2:0]  r_mode;
  logic [2:0]  r_dim;
  logic [7:0]  r_pt;
  logic [11:0] r_addr;
  logic signed [15:0] r_val;
  logic [2:0]  r_kind;
  logic [6:0]  r_side;
  logic [15:0] r_weight;

  // Commit sequencer state.
  logic [4:0]  q;
  logic [12:0] g;
  logic [31:0] cut;
  logic [31:0] ag, ae, ab;
  logic signed [23:0] av;
  logic signed [16:0] dist_val;
  logic signed [19:0] iv;
  logic [47:0] creg;

  // Result.
  logic [47:0] res_density;
  logic        res_status;
  logic [47:0] out_density;
  logic        out_status;

  // Shared multiplier.
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;

  // Memories.
  logic            ev_we;
  logic [EAW-1:0]  ev_waddr, ev_raddr;
  logic [15:0]     ev_rdata;
  logic            tb_we;
  logic [TAW-1:0]  tb_waddr, tb_raddr;
  logic [15:0]     tb_rdata;
  logic            acc_we;
  logic [GIW-1:0]  acc_raddr;
  logic [47:0]     acc_wdata, acc_rdata;

  // Derived limits and request checks.
  logic [4:0]  nd;
  logic [12:0] np;
  logic [4:0]  dim5;
  logic [12:0] pt13;
  logic        d_out, d_ok, pt_ok, pt_act, addr_ok;
  logic [DIW-1:0] qi, di_w;
  logic [GIW-1:0] gi;

  // Per-dimension combinational values.
  logic [2:0]  cur_kind;
  logic [8:0]  cur_side;
  logic signed [15:0] ev_sval;
  logic [8:0]  xi, di;
  logic signed [33:0] prod;
  logic [33:0] mag;
  logic [25:0] mval;
  logic [15:0] mc;
  logic [32:0] sq_sum;
  logic [31:0] sq_sat;
  logic        dim_step, step_skip, q_last, g_last;
  logic signed [25:0] tval;
  logic [48:0] pval;
  logic [63:0] c64;
  logic [48:0] acc_sum;
  logic [47:0] acc_old;

  function automatic logic [8:0] table_coord(input logic signed [15:0] c,
                                             input logic [8:0] side);
    logic [8:0] i;
    i = (c < 0) ? 9'd0 : {1'b0, c[15:8]};
    return (i > side - 9'd1) ? side - 9'd1 : i;
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = {7'd0, out_status, out_density};

  // Limits and address checks for the latched request.
  always_comb begin
    nd = ({1'b0, act_dims} > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : {1'b0, act_dims};
    np = ({4'd0, act_pts} > 13'(MAX_EVAL)) ? 13'(MAX_EVAL) : {4'd0, act_pts};
    dim5 = {2'd0, r_dim};
    pt13 = {5'd0, r_pt};
    d_out = dim5 >= nd;
    d_ok = 32'(r_dim) < MAX_DIMS;
    pt_ok = 32'(r_pt) < MAX_EVAL;
    pt_act = pt13 < np;
    addr_ok = 32'(r_addr) < TBL_WORDS;
    di_w = dim5[DIW-1:0];
    qi = q[DIW-1:0];
    gi = g[GIW-1:0];
  end

  // Distance and kernel arithmetic for the current dimension.
  always_comb begin
    cur_kind = dim_kernel[qi];
    cur_side = ({2'd0, dim_table_side[qi]} > 9'(TABLE_SIDE)) ? 9'(TABLE_SIDE)
               : {2'd0, dim_table_side[qi]};
    ev_sval = $signed(ev_rdata);
    xi = table_coord(ev_sval, cur_side);
    di = table_coord(staged[qi], cur_side);
    prod = mul_p[33:0];
    mag = (prod < 0) ? 34'(-prod) : 34'(prod);
    mval = mag[33:8];
    mc = (mval > 26'd65535) ? 16'hFFFF : mval[15:0];
    sq_sat = 32'd0;
    case (cur_kind)
      KIND_GAUSS: sq_sum = {1'b0, ag} + {1'b0, mul_p[31:0]};
      KIND_EPA:   sq_sum = {1'b0, ae} + {1'b0, mul_p[31:0]};
      default:    sq_sum = {1'b0, ab} + {1'b0, mul_p[31:0]};
    endcase
    sq_sat = sq_sum[32] ? SQ_SAT : sq_sum[31:0];
    dim_step = 1'b0;
    step_skip = 1'b0;
    case (state)
      S_KERN: dim_step = !(cur_kind == KIND_VM || cur_kind == KIND_GAUSS ||
                           cur_kind == KIND_EPA || cur_kind == KIND_BOX ||
                           cur_kind == KIND_DELTA);
      S_VM2: dim_step = 1'b1;
      S_SQ: begin
        dim_step = (cur_kind == KIND_DELTA);
        step_skip = (cur_kind == KIND_DELTA) && (prod > 0) && (mval >= 26'd256);
      end
      S_ACC: begin
        dim_step = 1'b1;
        step_skip = (cur_kind == KIND_GAUSS) ? (sq_sat > cut) : (sq_sat > ONE_Q16);
      end
      default: dim_step = 1'b0;
    endcase
    q_last = (q + 5'd1) >= nd;
    g_last = (g + 13'd1) >= np;
    tval = 26'(av) - $signed({3'd0, ag[31:9]});
  end

  // Contribution shift and accumulator add.
  always_comb begin
    pval = mul_p[48:0];
    c64 = 64'd0;
    if (iv < -20'sd32) begin
      c64 = 64'd0;
    end else if (iv <= 20'sd31) begin
      c64 = {15'd0, pval} >> 6'(20'sd31 - iv);
    end else if (pval == 49'd0) begin
      c64 = 64'd0;
    end else if (iv > 20'sd44) begin
      c64 = {16'd0, ACC_SAT};
    end else begin
      c64 = {15'd0, pval} << 4'(iv - 20'sd31);
    end
    acc_old = acc_valid[gi] ? acc_rdata : 48'd0;
    acc_sum = {1'b0, acc_old} + {1'b0, creg};
    acc_wdata = acc_sum[48] ? ACC_SAT : acc_sum[47:0];
  end

  // Shared multiplier operand select.
  always_comb begin
    mul_a = 34'sd0;
    mul_b = 18'sd0;
    case (state)
      S_EXEC: begin
        mul_a = $signed(34'(cutoff));
        mul_b = $signed(18'(cutoff));
      end
      S_KERN: begin
        mul_a = 34'(dist_val);
        mul_b = (cur_kind == KIND_VM) ? $signed(PHASE_SCALE) : 18'(dim_scale[qi]);
      end
      S_VM1: begin
        mul_a = 34'(dim_scale[qi]);
        mul_b = 18'(cos_q14(mul_p[23:18]));
      end
      S_SQ: begin
        mul_a = $signed(34'(mc));
        mul_b = $signed(18'(mc));
      end
      S_EXP1: begin
        mul_a = 34'(tval);
        mul_b = $signed(LOG2E_Q8);
      end
      S_EXP2: begin
        mul_a = $signed(34'(r_weight));
        mul_b = $signed(18'(exp2_frac(mul_p[15:12])));
      end
      S_EXP3: begin
        mul_a = $signed(34'(mul_p[31:0]));
        mul_b = $signed(18'(ONE_Q16 - ae));
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 18'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= 52'(mul_a * mul_b);
  end

  // Memory ports.
  always_comb begin
    ev_we = (state == S_EXEC) && (r_mode == MODE_EVAL) && d_ok && pt_ok;
    ev_waddr = EAW'(32'(r_dim) * MAX_EVAL + 32'(r_pt));
    ev_raddr = EAW'(32'(q) * MAX_EVAL + 32'(g));
    tb_we = (state == S_EXEC) && (r_mode == MODE_LUT) && d_ok && addr_ok;
    tb_waddr = TAW'(32'(r_dim) * TBL_WORDS + 32'(r_addr));
    tb_raddr = TAW'(32'(q) * TBL_WORDS + 32'(xi) + 32'(cur_side) * 32'(di));
    acc_we = (state == S_WR);
    acc_raddr = (r_mode == MODE_COMMIT) ? gi : pt13[GIW-1:0];
  end

  mkde_ram #(.WIDTH(16), .DEPTH(EV_DEPTH)) u_eval_ram (
    .clk(clk), .we(ev_we), .waddr(ev_waddr), .wdata(r_val),
    .raddr(ev_raddr), .rdata(ev_rdata)
  );

  mkde_ram #(.WIDTH(16), .DEPTH(TB_DEPTH)) u_table_ram (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(r_val),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );

  mkde_ram #(.WIDTH(48), .DEPTH(MAX_EVAL)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(gi), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  // Sequencer, setup registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      act_dims <= 4'd1;
      act_pts <= 9'd1;
      cutoff <= 16'd768;
      acc_valid <= '0;
      r_mode <= MODE_SETUP;
      for (int i = 0; i < MAX_DIMS; i++) begin
        dim_kernel[i] <= 3'd0;
        dim_scale[i] <= 16'sd0;
        dim_table_side[i] <= 7'd0;
        staged[i] <= 16'sd0;
      end
    end else begin
      // Configuration writes; indexes past the list are dropped.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DIMS:   act_dims <= cfg_data[3:0];
          CFG_POINTS: act_pts <= cfg_data[8:0];
          CFG_CUTOFF: cutoff <= cfg_data;
          default: ;
        endcase
      end

      // The output register empties unless a new result loads in this cycle.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            r_mode <= s_tuser;
            r_dim <= s_tdata[2:0];
            r_pt <= s_tdata[10:3];
            r_addr <= s_tdata[22:11];
            r_val <= $signed(s_tdata[38:23]);
            r_kind <= s_tdata[41:39];
            r_side <= s_tdata[48:42];
            r_weight <= s_tdata[64:49];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_density <= 48'd0;
          res_status <= 1'b0;
          state <= S_OUT;
          case (r_mode)
            MODE_SETUP: begin
              res_status <= d_out;
              if (d_ok) begin
                dim_kernel[di_w] <= r_kind;
                dim_scale[di_w] <= r_val;
                dim_table_side[di_w] <= r_side;
              end
            end
            MODE_EVAL:  res_status <= d_out || !pt_act;
            MODE_LUT:   res_status <= d_out || !addr_ok;
            MODE_CLEAR: acc_valid <= '0;
            MODE_STAGE: begin
              res_status <= d_out;
              if (d_ok) begin
                staged[di_w] <= r_val;
              end
            end
            MODE_COMMIT: state <= S_CUT;
            MODE_READ:   state <= S_RDACC;
            default: ;
          endcase
        end
        S_RDACC: begin
          res_status <= !pt_act;
          res_density <= (pt_act && acc_valid[pt13[GIW-1:0]]) ? acc_rdata : 48'd0;
          state <= S_OUT;
        end
        S_CUT: begin
          cut <= mul_p[31:0];
          g <= 13'd0;
          state <= (np == 13'd0) ? S_OUT : S_PT;
        end
        S_PT: begin
          ag <= 32'd0;
          ae <= 32'd0;
          ab <= 32'd0;
          av <= 24'sd0;
          q <= 5'd0;
          state <= (nd == 5'd0) ? S_EXP1 : S_FETCH;
        end
        S_FETCH: state <= S_COORD;
        S_COORD: begin
          if (cur_side != 9'd0) begin
            state <= S_TBL;
          end else begin
            dist_val <= 17'(ev_sval) - 17'(staged[qi]);
            state <= S_KERN;
          end
        end
        S_TBL: begin
          dist_val <= 17'($signed(tb_rdata));
          state <= S_KERN;
        end
        S_KERN: begin
          if (cur_kind == KIND_VM) begin
            state <= S_VM1;
          end else if (!dim_step) begin
            state <= S_SQ;
          end
        end
        S_VM1: state <= S_VM2;
        S_VM2: av <= av + 24'(mul_p >>> 14);
        S_SQ: begin
          if (!dim_step) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          case (cur_kind)
            KIND_GAUSS: ag <= sq_sat;
            KIND_EPA:   ae <= sq_sat;
            default:    ab <= sq_sat;
          endcase
        end
        S_EXP1: state <= S_EXP2;
        S_EXP2: begin
          iv <= mul_p[35:16];
          state <= S_EXP3;
        end
        S_EXP3: state <= S_EXP4;
        S_EXP4: begin
          creg <= (c64 > {16'd0, ACC_SAT}) ? ACC_SAT : c64[47:0];
          state <= S_WR;
        end
        S_WR: begin
          acc_valid[gi] <= 1'b1;
          if (g_last) begin
            state <= S_OUT;
          end else begin
            g <= g + 13'd1;
            state <= S_PT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_density <= res_density;
            out_status <= res_status;
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // End of one dimension: next dimension, exp stage, next point, or end of the commit.
      if (dim_step) begin
        if (step_skip) begin
          if (g_last) begin
            state <= S_OUT;
          end else begin
            g <= g + 13'd1;
            state <= S_PT;
          end
        end else if (q_last) begin
          state <= S_EXP1;
        end else begin
          q <= q + 5'd1;
          state <= S_FETCH;
        end
      end
    end
  end

  // A new request is never taken in the cycle after one was accepted.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  // Memory fetches stay within the active points and dimensions.
  a_fetch_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> ((q < nd) && (g < np)))
    else $error("commit fetch outside active range");

  // A point that reaches the exp stage has its epanechnikov sum within one.
  a_epa_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP3) |-> (ae <= ONE_Q16))
    else $error("epanechnikov sum above one in exp stage");

  // The cutoff square is followed by a point setup or an empty commit.
  a_cut_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_CUT) |=> ((state == S_PT) || (state == S_OUT)))
    else $error("bad sequence after cutoff square");

endmodule

// ===== tb/tb_mixed_kernel_density_eval_unit.sv =====
`timescale 1ns / 100ps

module tb_mixed_kernel_density_eval_unit;
  import mkde_pkg::*;

  localparam logic [2:0] MODE_IDLE = 3'd7;
  localparam int STALL_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 250;

  typedef struct {
    logic [2:0]         mode;
    logic [2:0]         dim;
    logic [7:0]         pt;
    logic [11:0]        addr;
    logic signed [15:0] value;
    logic [2:0]         kind;
    logic [6:0]         side;
    logic [15:0]        weight;
  } density_req_t;

  typedef struct {
    logic [47:0] density;
    logic        status;
  } density_res_t;

  // Cosine quarter wave (Q1.14) and 2^(k/16) (Q1.15) used by the predictor.
  localparam int COS_STEPS [17] = '{16384, 16305, 16069, 15679, 15137, 14449, 13623,
    12665, 11585, 10394, 9102, 7723, 6270, 4756, 3196, 1606, 0};
  localparam longint POW2_STEPS [16] = '{32768, 34219, 35734, 37316, 38968, 40693,
    42495, 44376, 46341, 48393, 50535, 52773, 55109, 57549, 60097, 62757};

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  mixed_kernel_density_eval_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block's registers and memories.
  int unsigned        dims_reg = 1;
  int unsigned        points_reg = 1;
  longint unsigned    cutoff_reg = 768;
  logic [2:0]         kernel_of [8] = '{default: '0};
  logic signed [15:0] scale_of [8] = '{default: '0};
  logic [6:0]         table_side_of [8] = '{default: '0};
  logic signed [15:0] staged_of [8] = '{default: '0};
  logic signed [15:0] eval_coord_mem [2048];
  logic signed [15:0] distance_mem [32768];
  logic [47:0]        density_acc [256] = '{default: '0};

  density_req_t pending_reqs[$];
  density_res_t expected_density[$];
  density_req_t cur_req;

  bit s_took, m_took;
  int send_gap, recv_gap;
  bit quiet_mode;
  int mismatches, results_seen, commits_sent, reads_sent, phases_run, queued_items;
  int idle_cycles;

  function automatic int grid_index(input int c, input int side);
    int i;
    i = (c < 0) ? 0 : (c >>> 8);
    return (i > side - 1) ? side - 1 : i;
  endfunction

  function automatic longint cos_of_distance(input longint dv);
    longint phase_prod;
    logic [5:0] ph;
    int r;
    phase_prod = dv * 10430;
    ph = phase_prod[23:18];
    r = ph[3:0];
    case (ph[5:4])
      2'd0: return COS_STEPS[r];
      2'd1: return -COS_STEPS[16 - r];
      2'd2: return -COS_STEPS[r];
      default: return COS_STEPS[16 - r];
    endcase
  endfunction

  // Adds one weighted kernel product to every active evaluation point that no kernel rejects.
  function automatic void commit_density(input logic [15:0] w);
    int nd, np, side, xc, dc;
    longint unsigned cut, ag, ae, ab, m, sq, p, c, sum;
    longint av, dval, prod, t, y, i;
    int f;
    bit skip;
    nd = (dims_reg > 8) ? 8 : dims_reg;
    np = (points_reg > 256) ? 256 : points_reg;
    cut = cutoff_reg * cutoff_reg;
    for (int g = 0; g < np; g++) begin
      ag = 0; ae = 0; ab = 0; av = 0; skip = 0;
      for (int q = 0; q < nd && !skip; q++) begin
        xc = eval_coord_mem[q * 256 + g];
        dc = staged_of[q];
        side = (table_side_of[q] > 64) ? 64 : table_side_of[q];
        if (side > 0)
          dval = distance_mem[q * 4096 + grid_index(xc, side) + side * grid_index(dc, side)];
        else
          dval = xc - dc;
        if (kernel_of[q] == KIND_VM) begin
          av += (longint'(scale_of[q]) * cos_of_distance(dval)) >>> 14;
          continue;
        end
        prod = dval * longint'(scale_of[q]);
        m = (prod < 0 ? -prod : prod) >> 8;
        sq = (m > 65535) ? 65535 * 65535 : m * m;
        case (kernel_of[q])
          KIND_GAUSS: begin
            ag = (ag + sq > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : ag + sq;
            skip = ag > cut;
          end
          KIND_EPA: begin
            ae = (ae + sq > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : ae + sq;
            skip = ae > 65536;
          end
          KIND_BOX: begin
            ab = (ab + sq > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : ab + sq;
            skip = ab > 65536;
          end
          KIND_DELTA: skip = (prod > 0) && (m >= 256);
          default: ;
        endcase
      end
      if (skip) continue;
      t = av - longint'(ag >> 9);
      y = (t * 369) >>> 8;
      i = y >>> 8;
      f = int'(y - i * 256);
      p = longint'(w) * POW2_STEPS[(f >> 4) & 15] * (65536 - ae);
      if (i <= -33) c = 0;
      else if (i <= 31) c = p >> (31 - i);
      else if (p == 0) c = 0;
      else if (i - 31 > 13) c = ACC_SAT;
      else c = p << (i - 31);
      if (c > ACC_SAT) c = ACC_SAT;
      sum = longint'(density_acc[g]) + c;
      density_acc[g] = (sum > ACC_SAT) ? ACC_SAT : sum[47:0];
    end
  endfunction

  // Applies one accepted request to the shadow state and queues its result.
  function automatic void predict_request(input density_req_t r);
    density_res_t res;
    int nd, np;
    bit d_out;
    nd = (dims_reg > 8) ? 8 : dims_reg;
    np = (points_reg > 256) ? 256 : points_reg;
    d_out = r.dim >= nd;
    res.density = '0;
    res.status = 1'b0;
    case (r.mode)
      MODE_SETUP: begin
        res.status = d_out;
        kernel_of[r.dim] = r.kind;
        scale_of[r.dim] = r.value;
        table_side_of[r.dim] = r.side;
      end
      MODE_EVAL: begin
        res.status = d_out || (r.pt >= np);
        eval_coord_mem[r.dim * 256 + r.pt] = r.value;
      end
      MODE_LUT: begin
        res.status = d_out;
        distance_mem[r.dim * 4096 + r.addr] = r.value;
      end
      MODE_CLEAR: density_acc = '{default: '0};
      MODE_STAGE: begin
        res.status = d_out;
        staged_of[r.dim] = r.value;
      end
      MODE_COMMIT: commit_density(r.weight);
      MODE_READ: begin
        if (r.pt < np) res.density = density_acc[r.pt];
        else res.status = 1'b1;
      end
      default: ;
    endcase
    expected_density.push_back(res);
  endfunction

  // Sampling at the rising edge: requests, results and the watchdog.
  always @(posedge clk) begin
    density_res_t exp_res;
    s_took = 0;
    m_took = 0;
    if (!rst) begin
      idle_cycles++;
      if (s_tvalid && s_tready) begin
        s_took = 1;
        idle_cycles = 0;
        predict_request(cur_req);
      end
      if (m_tvalid && m_tready) begin
        m_took = 1;
        idle_cycles = 0;
        results_seen++;
        if (expected_density.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result density=%0d status=%0d",
                     m_tdata[47:0], m_tdata[48]);
        end else begin
          exp_res = expected_density.pop_front();
          if (m_tdata[47:0] !== exp_res.density || m_tdata[48] !== exp_res.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected density=%0d status=%0d, got %0d/%0d",
                       results_seen, exp_res.density, exp_res.status,
                       m_tdata[47:0], m_tdata[48]);
          end
        end
      end
      if (cfg_valid && cfg_ready) idle_cycles = 0;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return quiet_mode ? 0 : $urandom_range(0, 18);
  endfunction

  // Request driver, fed from the pending queue.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_tvalid || s_took) begin
      if (s_tvalid) send_gap = draw_gap();
      if (send_gap == 0 && pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_tuser <= cur_req.mode;
        s_tdata <= {7'd0, cur_req.weight, cur_req.side, cur_req.kind, cur_req.value,
                    cur_req.addr, cur_req.pt, cur_req.dim};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // Result receiver with random back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_took) recv_gap = draw_gap();
      if (recv_gap > 0) begin
        m_tready <= 1'b0;
        recv_gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data[15:0];
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_DIMS:   dims_reg = data & 4'hF;
      CFG_POINTS: points_reg = data & 9'h1FF;
      default:    cutoff_reg = data & 16'hFFFF;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every request is sent and every result is back.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_tvalid || expected_density.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic density_req_t rand_req(input logic [2:0] mode);
    density_req_t r;
    r.mode = mode;
    r.dim = $urandom_range(0, 7);
    r.pt = $urandom_range(0, 255);
    r.addr = $urandom_range(0, 4095);
    r.value = $urandom_range(0, 65535);
    r.kind = $urandom_range(0, 7);
    r.side = $urandom_range(0, 127);
    r.weight = $urandom_range(0, 65535);
    return r;
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 1024) - 512;
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return $urandom_range(0, 65535);
      default: return $urandom_range(16, 400);
    endcase
  endfunction

  task automatic send(input density_req_t r);
    pending_reqs.push_back(r);
    queued_items++;
    if (r.mode == MODE_COMMIT) commits_sent++;
    if (r.mode == MODE_READ) reads_sent++;
  endtask

  // Harmless request that never makes a later commit read unwritten storage.
  task automatic send_noise(input int ndu);
    density_req_t r;
    case ($urandom_range(0, 4))
      0: r = rand_req(MODE_IDLE);
      1: begin
        r = rand_req(ndu < 8 ? MODE_SETUP : MODE_IDLE);
        if (ndu < 8) r.dim = $urandom_range(ndu, 7);
      end
      2: r = rand_req(MODE_LUT);
      3: begin
        r = rand_req(MODE_EVAL);
        r.value = pick_coord();
      end
      default: r = rand_req(MODE_READ);
    endcase
    send(r);
  endtask

  // One configuration, a well-formed load, then stage, commit and read rounds with noise requests and clears mixed in.
  task automatic run_phase();
    density_req_t r;
    int nd, np, ndu, npu, side;
    case ($urandom_range(0, 9))
      0: nd = 0;
      1: nd = 15;
      default: nd = $urandom_range(1, 8);
    endcase
    if (nd == 0) begin
      case ($urandom_range(0, 2))
        0: np = 256;
        1: np = 511;
        default: np = $urandom_range(1, 256);
      endcase
    end else begin
      np = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    end
    write_reg(CFG_DIMS, nd);
    write_reg(CFG_POINTS, np);
    case ($urandom_range(0, 3))
      0: write_reg(CFG_CUTOFF, 0);
      1: write_reg(CFG_CUTOFF, 65535);
      default: write_reg(CFG_CUTOFF, $urandom_range(128, 2048));
    endcase
    quiet_mode = ($urandom_range(0, 3) == 0);
    ndu = (nd > 8) ? 8 : nd;
    npu = (np > 256) ? 256 : np;
    phases_run++;

    // Kernel setup, with a small filled distance table now and then.
    for (int d = 0; d < ndu; d++) begin
      side = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
      r = rand_req(MODE_SETUP);
      r.dim = d;
      r.kind = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      r.value = pick_scale();
      r.side = side;
      send(r);
      for (int a = 0; a < side * side; a++) begin
        r = rand_req(MODE_LUT);
        r.dim = d;
        r.addr = a;
        r.value = $urandom_range(0, 1200) - 600;
        send(r);
      end
    end
    for (int d = 0; d < ndu; d++)
      for (int p = 0; p < npu; p++) begin
        r = rand_req(MODE_EVAL);
        r.dim = d;
        r.pt = p;
        r.value = pick_coord();
        send(r);
      end

    repeat ($urandom_range(1, 3)) begin
      for (int d = 0; d < ndu; d++) begin
        r = rand_req(MODE_STAGE);
        r.dim = d;
        r.value = pick_coord();
        send(r);
      end
      r = rand_req(MODE_COMMIT);
      case ($urandom_range(0, 5))
        0: r.weight = 16'hFFFF;
        1: r.weight = 16'h0000;
        default: ;
      endcase
      send(r);
      if (npu <= 4) begin
        for (int p = 0; p <= npu; p++) begin
          r = rand_req(MODE_READ);
          r.pt = p;
          send(r);
        end
      end else begin
        r = rand_req(MODE_READ); r.pt = 0; send(r);
        r = rand_req(MODE_READ); r.pt = npu - 1; send(r);
        r = rand_req(MODE_READ); send(r);
      end
      repeat ($urandom_range(0, 2)) send_noise(ndu);
      if ($urandom_range(0, 5) == 0) send(rand_req(MODE_CLEAR));
    end
  endtask

  initial begin
    density_req_t r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening: field extremes, every mode and the special cases.
    write_reg(CFG_DIMS, 2);
    write_reg(CFG_POINTS, 2);
    write_reg(CFG_CUTOFF, 65535);
    r = rand_req(MODE_SETUP); r.dim = 0; r.kind = KIND_GAUSS; r.value = 256; r.side = 0;
    send(r);
    r = rand_req(MODE_SETUP); r.dim = 1; r.kind = KIND_VM; r.value = 16'h7FFF; r.side = 0;
    send(r);
    r = rand_req(MODE_EVAL); r.dim = 0; r.pt = 0; r.value = 16'h8000; send(r);
    r = rand_req(MODE_EVAL); r.dim = 0; r.pt = 1; r.value = 16'h7FFF; send(r);
    r = rand_req(MODE_EVAL); r.dim = 1; r.pt = 0; r.value = 0; send(r);
    r = rand_req(MODE_EVAL); r.dim = 1; r.pt = 1; r.value = 16'hFF00; send(r);
    r = rand_req(MODE_EVAL); r.dim = 7; r.pt = 255; r.value = 16'h1234; send(r);
    r = rand_req(MODE_STAGE); r.dim = 0; r.value = 16'h7F00; send(r);
    r = rand_req(MODE_STAGE); r.dim = 1; r.value = 16'h0100; send(r);
    r = rand_req(MODE_COMMIT); r.weight = 16'hFFFF; send(r);
    r = rand_req(MODE_COMMIT); r.weight = 16'h0000; send(r);
    for (int p = 0; p < 3; p++) begin
      r = rand_req(MODE_READ); r.pt = p; send(r);
    end
    r = rand_req(MODE_READ); r.pt = 255; send(r);
    // A scale of zero makes the scaled distance zero.
    r = rand_req(MODE_SETUP); r.dim = 0; r.kind = KIND_DELTA; r.value = 0; r.side = 0;
    send(r);
    r = rand_req(MODE_COMMIT); r.weight = 16'h8000; send(r);
    r = rand_req(MODE_READ); r.pt = 1; send(r);
    r = rand_req(MODE_CLEAR); send(r);
    r = rand_req(MODE_READ); r.pt = 0; send(r);
    // Inactive dimension: written but flagged, including the widest table side.
    r = rand_req(MODE_SETUP); r.dim = 7; r.kind = 3'd7; r.side = 7'd127; send(r);
    r = rand_req(MODE_LUT); r.dim = 7; r.addr = 12'hFFF; r.value = 16'h8000; send(r);
    r = rand_req(MODE_STAGE); r.dim = 5; send(r);
    send(rand_req(MODE_IDLE));
    wait_drained();

    // Random phases, each starting from an idle block.
    queued_items = 0;
    while (queued_items < RANDOM_ITEMS) begin
      run_phase();
      wait_drained();
    end

    $display("Covered %0d configuration phases, %0d commits and %0d reads.",
             phases_run, commits_sent, reads_sent);
    $display("Checked %0d results with %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_density.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== mixed_kernel_density_eval_unit.f =====
rtl/mkde_pkg.sv
rtl/mkde_ram.sv
rtl/mixed_kernel_density_eval_unit.sv
tb/tb_mixed_kernel_density_eval_unit.sv
